@@ sv/alsp_pkg.sv @@
// ----------------------------------------------------------------------------
// alsp_pkg
// Shared types, codes and constants of the ascii-length sub-block parser.
// ----------------------------------------------------------------------------
package alsp_pkg;

  // default capacity of the byte position counter
  localparam int unsigned MAX_BLOCK_BYTES_DEF = 4096;

  // sub-block header layout
  localparam int unsigned TYPE_BYTES = 2;
  localparam int unsigned LEN_DIGITS = 3;
  localparam int unsigned HDR_BYTES  = TYPE_BYTES + LEN_DIGITS;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BLEN_W = 12;
  localparam int unsigned TID_W  = 16;
  localparam int unsigned CLEN_W = 10;
  localparam int unsigned HCNT_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  // ascii digit bounds
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

  // byte tag
  typedef enum logic [1:0] {
    PART_TYPE    = 2'd0,
    PART_LEN     = 2'd1,
    PART_CONTENT = 2'd2,
    PART_IGNORE  = 2'd3
  } part_e;

  // per-byte status
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_HDR_TRUNC = 3'd1,
    ST_OVERRUN   = 3'd2,
    ST_BAD_DIGIT = 3'd3,
    ST_PAST_END  = 3'd4
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_LENGTH = 1'b0,
    CFG_TARGET_ID    = 1'b1
  } cfg_idx_e;

  // one accepted input word
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              block_start;
  } item_t;

  // one result word
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    part_e             part;
    logic [CLEN_W-1:0] content_length;
    logic              type_matches;
    logic              first_match_res;
    logic              end_of_subblock;
    status_e           status;
  } res_t;

endpackage

@@ sv/alsp_in_if.sv @@
// ----------------------------------------------------------------------------
// alsp_in_if
// Input byte channel: valid/ready handshake with one raw byte per word.
// ----------------------------------------------------------------------------
interface alsp_in_if import alsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

@@ sv/alsp_out_if.sv @@
// ----------------------------------------------------------------------------
// alsp_out_if
// Result channel: valid/ready handshake with one tagged byte per word.
// ----------------------------------------------------------------------------
interface alsp_out_if import alsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic [1:0]        part;
  logic [CLEN_W-1:0] content_length;
  logic              type_matches;
  logic              first_match_res;
  logic              end_of_subblock;
  logic [2:0]        status;

  modport source (output valid, output byte_out, output part, output content_length,
                  output type_matches, output first_match_res, output end_of_subblock,
                  output status, input ready);
  modport sink   (input valid, input byte_out, input part, input content_length,
                  input type_matches, input first_match_res, input end_of_subblock,
                  input status, output ready);
endinterface

@@ sv/alsp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// alsp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface alsp_cfg_if import alsp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/ascii_length_tlv_subblock_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ascii_length_tlv_subblock_parser_unit
// Walks a block of type / ascii-length / content sub-blocks one byte a word.
//
//   channel  dir  handshake     payload
//   in_if    in   valid/ready   data_byte, block_start
//   out_if   out  valid/ready   byte_out, part, content_length, flags, status
//   cfg_if   in   valid/ready   index (0 block_length, 1 target_id), data
//
// One byte per cycle sustained while out_if does not stall.
// The input register and the result register are the only pipeline stages;
// the walk state updates when a byte moves from one to the other.
// A stall on out_if holds the result and backs up into the input register.
// After reset the walk is stopped: bytes are tagged ignored until block_start.
// ----------------------------------------------------------------------------
module ascii_length_tlv_subblock_parser_unit import alsp_pkg::*; #(
  parameter int unsigned MaxBlockBytes = MAX_BLOCK_BYTES_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  alsp_in_if.sink    in_if,
  alsp_out_if.source out_if,
  alsp_cfg_if.sink   cfg_if
);

  logic [BLEN_W-1:0] blen_q;
  logic [TID_W-1:0]  tid_q;
  item_t             in_item;
  item_t             item;
  logic              item_valid;
  logic              step;
  res_t              res;
  logic              out_valid_q;
  res_t              out_q;

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q <= '0;
      tid_q  <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_idx_e'(cfg_if.index))
        CFG_BLOCK_LENGTH: blen_q <= cfg_if.data[BLEN_W-1:0];
        CFG_TARGET_ID:    tid_q  <= cfg_if.data[TID_W-1:0];
        default:          ;
      endcase
    end
  end

  // input register
  assign in_item.data_byte   = in_if.data_byte;
  assign in_item.block_start = in_if.block_start;

  alsp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .consume_i    (step)
  );

  // a byte moves on when the result register is free or drains
  assign step = item_valid && (!out_valid_q || out_if.ready);

  alsp_walker #(
    .MaxBlockBytes (MaxBlockBytes)
  ) u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .step_i         (step),
    .block_length_i (blen_q),
    .target_id_i    (tid_q),
    .res_o          (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.byte_out        = out_q.data_byte;
  assign out_if.part            = out_q.part;
  assign out_if.content_length  = out_q.content_length;
  assign out_if.type_matches    = out_q.type_matches;
  assign out_if.first_match_res = out_q.first_match_res;
  assign out_if.end_of_subblock = out_q.end_of_subblock;
  assign out_if.status          = out_q.status;

endmodule

@@ sv/alsp_in_stage.sv @@
// ----------------------------------------------------------------------------
// alsp_in_stage
// Input register: holds one accepted word until the walker consumes it.
// ----------------------------------------------------------------------------
module alsp_in_stage import alsp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  consume_i
);

  logic  valid_q, valid_d;
  item_t item_q;

  // accept whenever the held word is empty or leaves this cycle
  assign in_ready_o = !valid_q || consume_i;

  always_comb begin
    valid_d = valid_q;
    if (consume_i) valid_d = 1'b0;
    if (in_valid_i && in_ready_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ sv/alsp_walker.sv @@
// ----------------------------------------------------------------------------
// alsp_walker
// Sub-block walk state and the per-byte tagging, checking and matching logic.
// ----------------------------------------------------------------------------
module alsp_walker import alsp_pkg::*; #(
  parameter int unsigned MaxBlockBytes = MAX_BLOCK_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  item_t             item_i,
  input  logic              step_i,
  input  logic [BLEN_W-1:0] block_length_i,
  input  logic [TID_W-1:0]  target_id_i,
  output res_t              res_o
);

  localparam int unsigned PosW = $clog2(MaxBlockBytes);
  localparam int unsigned CmpW = ((PosW + 1 > BLEN_W) ? PosW + 1 : BLEN_W) + 2;
  localparam logic [PosW-1:0] PosMax = PosW'(MaxBlockBytes - 1);

  // walk state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW:0]     start_q, start_d;
  logic [HCNT_W-1:0] hcnt_q, hcnt_d;
  logic [TID_W-1:0]  type_q, type_d;
  logic [CLEN_W-1:0] acc_q, acc_d;
  logic [CLEN_W-1:0] rem_q, rem_d;
  logic              seen_q, seen_d;
  logic              stop_q, stop_d;
  logic              cmatch_q, cmatch_d;
  logic              cfirst_q, cfirst_d;

  // state as seen by this byte, after a block restart
  logic [PosW-1:0]   pos_e;
  logic [PosW:0]     start_e;
  logic [HCNT_W-1:0] hcnt_e;
  logic [TID_W-1:0]  type_e;
  logic [CLEN_W-1:0] acc_e;
  logic [CLEN_W-1:0] rem_e;
  logic              seen_e, stop_e, cmatch_e, cfirst_e;

  logic [BYTE_W-1:0] b;
  logic [CmpW-1:0]   blen_x;
  logic              past_end, hdr_trunc, is_digit, overrun, match_now;
  logic [CLEN_W-1:0] acc_new, rem_dec;
  logic [CmpW-1:0]   sub_end;

  assign b = item_i.data_byte;

  // restart view
  always_comb begin
    pos_e    = pos_q;
    start_e  = start_q;
    hcnt_e   = hcnt_q;
    type_e   = type_q;
    acc_e    = acc_q;
    rem_e    = rem_q;
    seen_e   = seen_q;
    stop_e   = stop_q;
    cmatch_e = cmatch_q;
    cfirst_e = cfirst_q;
    if (item_i.block_start) begin
      pos_e    = '0;
      start_e  = '0;
      hcnt_e   = '0;
      type_e   = '0;
      acc_e    = '0;
      rem_e    = '0;
      seen_e   = 1'b0;
      stop_e   = 1'b0;
      cmatch_e = 1'b0;
      cfirst_e = 1'b0;
    end
  end

  // bound checks and digit accumulate
  assign blen_x    = CmpW'(block_length_i);
  assign past_end  = CmpW'(pos_e) >= blen_x;
  assign hdr_trunc = (CmpW'(start_e) + CmpW'(HDR_BYTES)) > blen_x;
  assign is_digit  = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
  assign acc_new   = (acc_e << 3) + (acc_e << 1) + CLEN_W'(b - ASCII_ZERO);
  assign sub_end   = CmpW'(start_e) + CmpW'(HDR_BYTES) + CmpW'(acc_new);
  assign overrun   = sub_end > blen_x;
  assign match_now = (type_e == target_id_i);
  assign rem_dec   = (rem_e != '0) ? rem_e - CLEN_W'(1) : rem_e;

  // per-byte step
  always_comb begin
    res_o                 = '0;
    res_o.data_byte       = b;
    res_o.part            = PART_IGNORE;
    res_o.status          = ST_OK;
    start_d  = start_e;
    hcnt_d   = hcnt_e;
    type_d   = type_e;
    acc_d    = acc_e;
    rem_d    = rem_e;
    seen_d   = seen_e;
    stop_d   = stop_e;
    cmatch_d = cmatch_e;
    cfirst_d = cfirst_e;
    if (stop_e || past_end) begin
      res_o.status = ST_PAST_END;
      stop_d       = 1'b1;
    end else if (hcnt_e == '0 && hdr_trunc) begin
      res_o.status = ST_HDR_TRUNC;
      stop_d       = 1'b1;
    end else if (hcnt_e < HCNT_W'(TYPE_BYTES)) begin
      res_o.part = PART_TYPE;
      type_d     = {type_e[TID_W-BYTE_W-1:0], b};
      hcnt_d     = hcnt_e + HCNT_W'(1);
    end else if (hcnt_e < HCNT_W'(HDR_BYTES)) begin
      res_o.part = PART_LEN;
      if (!is_digit) begin
        res_o.status = ST_BAD_DIGIT;
        stop_d       = 1'b1;
      end else begin
        acc_d                = acc_new;
        hcnt_d               = hcnt_e + HCNT_W'(1);
        res_o.content_length = acc_new;
        if (hcnt_e == HCNT_W'(HDR_BYTES - 1)) begin
          if (overrun) begin
            res_o.status = ST_OVERRUN;
            stop_d       = 1'b1;
          end else begin
            cmatch_d              = match_now;
            cfirst_d              = match_now && !seen_e;
            seen_d                = seen_e || match_now;
            rem_d                 = acc_new;
            res_o.type_matches    = match_now;
            res_o.first_match_res = match_now && !seen_e;
            if (acc_new == '0) begin
              res_o.end_of_subblock = 1'b1;
              start_d  = {1'b0, pos_e} + (PosW+1)'(1);
              hcnt_d   = '0;
              type_d   = '0;
              acc_d    = '0;
              rem_d    = '0;
              cmatch_d = 1'b0;
              cfirst_d = 1'b0;
            end
          end
        end
      end
    end else begin
      // content byte
      res_o.part            = PART_CONTENT;
      res_o.content_length  = acc_e;
      res_o.type_matches    = cmatch_e;
      res_o.first_match_res = cfirst_e;
      rem_d                 = rem_dec;
      if (rem_dec == '0) begin
        res_o.end_of_subblock = 1'b1;
        start_d  = {1'b0, pos_e} + (PosW+1)'(1);
        hcnt_d   = '0;
        type_d   = '0;
        acc_d    = '0;
        rem_d    = '0;
        cmatch_d = 1'b0;
        cfirst_d = 1'b0;
      end
    end
  end

  // saturating byte position
  assign pos_d = (pos_e < PosMax) ? pos_e + PosW'(1) : pos_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      start_q  <= '0;
      hcnt_q   <= '0;
      type_q   <= '0;
      acc_q    <= '0;
      rem_q    <= '0;
      seen_q   <= 1'b0;
      stop_q   <= 1'b1;
      cmatch_q <= 1'b0;
      cfirst_q <= 1'b0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      start_q  <= start_d;
      hcnt_q   <= hcnt_d;
      type_q   <= type_d;
      acc_q    <= acc_d;
      rem_q    <= rem_d;
      seen_q   <= seen_d;
      stop_q   <= stop_d;
      cmatch_q <= cmatch_d;
      cfirst_q <= cfirst_d;
    end
  end

  // any error or past-end byte leaves the walk stopped
  a_err_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.status != ST_OK |=> stop_q)
    else $error("walk not stopped after error byte");

  // a first match is always a match
  a_first_is_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.first_match_res |-> res_o.type_matches)
    else $error("first match without match");

  // a sub-block end closes the header state
  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.end_of_subblock |=> hcnt_q == '0 && rem_q == '0)
    else $error("sub-block end left header state");

  // header counter never runs past the header length
  a_hcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= HCNT_W'(HDR_BYTES))
    else $error("header count out of range");

endmodule

@@ tb/tb_ascii_length_tlv_subblock_parser_unit.sv @@
// ----------------------------------------------------------------------------
// tb_ascii_length_tlv_subblock_parser_unit
// Self-checking bench for the ascii-length sub-block parser. A cycle-free
// walker in the scoreboard predicts the tag, length, match flags and status
// of every accepted byte; results are checked in order. Directed blocks hit
// the truncation, overrun, bad-digit and past-end cases, then random blocks
// of mostly well-formed sub-blocks run under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_ascii_length_tlv_subblock_parser_unit;
  import alsp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned RANDOM_BYTES = 750;
  localparam int unsigned LARGE_BLOCK_BYTES = 200;

  // predicts the tagged word for every accepted byte and checks results
  class tlv_walk_scoreboard;
    bit [BLEN_W-1:0] blk_len;
    bit [TID_W-1:0]  target;
    bit [BLEN_W-1:0] pos;
    bit [BLEN_W-1:0] sub_start;
    bit [HCNT_W-1:0] hdr_cnt;
    bit [TID_W-1:0]  type_word;
    bit [CLEN_W-1:0] len_acc;
    bit [CLEN_W-1:0] remaining;
    bit              match_seen;
    bit              stopped = 1'b1;
    bit              cur_match;
    bit              cur_first;
    res_t            expected_q[$];
    int unsigned     errors;

    function void clear_subblock();
      hdr_cnt   = '0;
      type_word = '0;
      len_acc   = '0;
      remaining = '0;
      cur_match = 1'b0;
      cur_first = 1'b0;
    endfunction

    function void write_reg(cfg_idx_e idx, bit [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_BLOCK_LENGTH: blk_len = d[BLEN_W-1:0];
        CFG_TARGET_ID:    target  = d[TID_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(bit [BYTE_W-1:0] b, bit start);
      res_t r;
      r = '0;
      r.data_byte = b;
      r.part      = PART_IGNORE;
      r.status    = ST_OK;
      // block start restarts the walk at byte 0
      if (start) begin
        pos        = '0;
        sub_start  = '0;
        match_seen = 1'b0;
        clear_subblock();
        stopped    = 1'b0;
      end
      if (stopped || pos >= blk_len) begin
        r.status = ST_PAST_END;
        stopped  = 1'b1;
      end else if (hdr_cnt == 0 && sub_start + HDR_BYTES > blk_len) begin
        r.status = ST_HDR_TRUNC;
        stopped  = 1'b1;
      end else if (hdr_cnt < TYPE_BYTES) begin
        type_word = {type_word[7:0], b};
        hdr_cnt++;
        r.part = PART_TYPE;
      end else if (hdr_cnt < HDR_BYTES) begin
        r.part = PART_LEN;
        if (b < ASCII_ZERO || b > ASCII_NINE) begin
          r.status = ST_BAD_DIGIT;
          stopped  = 1'b1;
        end else begin
          len_acc = CLEN_W'(len_acc * 10 + (b - ASCII_ZERO));
          hdr_cnt++;
          r.content_length = len_acc;
          // last digit: range check, then the one type compare
          if (hdr_cnt == HDR_BYTES) begin
            if (sub_start + HDR_BYTES + len_acc > blk_len) begin
              r.status = ST_OVERRUN;
              stopped  = 1'b1;
            end else begin
              cur_match = (type_word == target);
              cur_first = cur_match && !match_seen;
              if (cur_match) match_seen = 1'b1;
              remaining         = len_acc;
              r.type_matches    = cur_match;
              r.first_match_res = cur_first;
              if (remaining == 0) begin
                r.end_of_subblock = 1'b1;
                sub_start = pos + 1'b1;
                clear_subblock();
              end
            end
          end
        end
      end else begin
        r.part            = PART_CONTENT;
        r.content_length  = len_acc;
        r.type_matches    = cur_match;
        r.first_match_res = cur_first;
        if (remaining > 0) remaining--;
        if (remaining == 0) begin
          r.end_of_subblock = 1'b1;
          sub_start = pos + 1'b1;
          clear_subblock();
        end
      end
      if (pos < MAX_BLOCK_BYTES_DEF - 1) pos++;
      expected_q.push_back(r);
    endfunction

    function void fail_field(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        fail_field("unexpected word, byte", 0, got.data_byte);
        return;
      end
      want = expected_q.pop_front();
      if (got.data_byte != want.data_byte)
        fail_field("byte_out", want.data_byte, got.data_byte);
      if (got.part != want.part)
        fail_field("part", want.part, got.part);
      if (got.content_length != want.content_length)
        fail_field("content_length", want.content_length, got.content_length);
      if (got.type_matches != want.type_matches)
        fail_field("type_matches", want.type_matches, got.type_matches);
      if (got.first_match_res != want.first_match_res)
        fail_field("first_match_res", want.first_match_res, got.first_match_res);
      if (got.end_of_subblock != want.end_of_subblock)
        fail_field("end_of_subblock", want.end_of_subblock, got.end_of_subblock);
      if (got.status != want.status)
        fail_field("status", want.status, got.status);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  alsp_in_if  in_ch ();
  alsp_out_if out_ch ();
  alsp_cfg_if cfg_ch ();

  ascii_length_tlv_subblock_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  tlv_walk_scoreboard sb = new;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  bit [BYTE_W-1:0] blk_bytes[$];

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    res_t got;
    got.data_byte       = out_ch.byte_out;
    got.part            = part_e'(out_ch.part);
    got.content_length  = out_ch.content_length;
    got.type_matches    = out_ch.type_matches;
    got.first_match_res = out_ch.first_match_res;
    got.end_of_subblock = out_ch.end_of_subblock;
    got.status          = status_e'(out_ch.status);
    if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_idx_e'(cfg_ch.index), cfg_ch.data);
    if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.data_byte, in_ch.block_start);
    if (out_ch.valid && out_ch.ready) sb.check_result(got);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // 0 none, 1 sender idle, 2 receiver stall, 3 both lightly
  function automatic void set_idle_mode(int unsigned mode);
    case (mode)
      1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
      3:       begin send_idle_pct = 10; recv_stall_pct = 10; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  // one input word; starts and ends at a falling edge, valid left high
  task automatic send_word(bit [BYTE_W-1:0] b, bit start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.block_start <= start;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, bit start);
    for (int i = 0; i < s.len(); i++) send_word(s[i], start && i == 0);
  endtask

  task automatic send_block();
    foreach (blk_bytes[i]) send_word(blk_bytes[i], i == 0);
  endtask

  // lower valid and wait until every predicted word has come back
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, bit [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // mostly well-formed sub-blocks with random content, some broken
  task automatic make_block(int unsigned blen, bit [TID_W-1:0] tid);
    int unsigned room;
    int unsigned span;
    int unsigned len;
    int unsigned idx;
    bit [BYTE_W-1:0] b;
    blk_bytes.delete();
    while (blk_bytes.size() < blen) begin
      room = blen - blk_bytes.size();
      if (room < HDR_BYTES) begin
        repeat (room) blk_bytes.push_back(BYTE_W'($urandom));
        break;
      end
      // type characters: target, small alphabet or any byte
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          blk_bytes.push_back(tid[15:8]);
          blk_bytes.push_back(tid[7:0]);
        end
        4, 5, 6: begin
          blk_bytes.push_back(BYTE_W'($urandom_range(8'h41, 8'h44)));
          blk_bytes.push_back(BYTE_W'($urandom_range(8'h41, 8'h44)));
        end
        default: begin
          blk_bytes.push_back(BYTE_W'($urandom));
          blk_bytes.push_back(BYTE_W'($urandom));
        end
      endcase
      span = room - HDR_BYTES;
      if (span < 999 && $urandom_range(99) < 6)
        len = $urandom_range(999, span + 1);
      else if ($urandom_range(9) == 0)
        len = $urandom_range(span < 999 ? span : 999, 0);
      else
        len = $urandom_range(span < 12 ? span : 12, 0);
      blk_bytes.push_back(BYTE_W'(len / 100 + ASCII_ZERO));
      blk_bytes.push_back(BYTE_W'((len / 10) % 10 + ASCII_ZERO));
      blk_bytes.push_back(BYTE_W'(len % 10 + ASCII_ZERO));
      // broken length character ends the walk
      if ($urandom_range(99) < 4) begin
        idx = blk_bytes.size() - 1 - $urandom_range(2);
        b = BYTE_W'($urandom);
        if (b >= ASCII_ZERO && b <= ASCII_NINE) b ^= 8'h40;
        blk_bytes[idx] = b;
        break;
      end
      if (len > span) break;
      repeat (len) blk_bytes.push_back(BYTE_W'($urandom));
    end
    // a few bytes past the end, sometimes a block cut short
    repeat ($urandom_range(2)) blk_bytes.push_back(BYTE_W'($urandom));
    if ($urandom_range(9) == 0 && blk_bytes.size() > 1)
      blk_bytes = blk_bytes[0:$urandom_range(blk_bytes.size() - 2)];
    if (blk_bytes.size() == 0) blk_bytes.push_back(BYTE_W'($urandom));
  endtask

  function automatic bit [TID_W-1:0] pick_target();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return {BYTE_W'($urandom_range(8'h41, 8'h44)),
                       BYTE_W'($urandom_range(8'h41, 8'h44))};
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned rand_bytes;
    int unsigned setting;
    int unsigned blen;
    int unsigned nblk;
    bit [TID_W-1:0] tid;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.block_start  = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_BLOCK_LENGTH;
    cfg_ch.data        = '0;
    quiet_cycles       = 0;
    set_idle_mode(0);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // byte before any block start is ignored
    send_word(8'h41, 1'b0);
    wait_results_drained();

    // empty block: first byte already past the end
    cfg_write(CFG_BLOCK_LENGTH, 16'd0);
    cfg_write(CFG_TARGET_ID, 16'h4142);
    send_word(8'h41, 1'b1);
    wait_results_drained();

    // first match with content, second match of zero length,
    // then a header that no longer fits and a byte after the stop
    cfg_write(CFG_BLOCK_LENGTH, 16'd15);
    send_text("AB001", 1'b1);
    send_word(8'hFF, 1'b0);
    send_text("AB000", 1'b0);
    send_text("ZZ", 1'b0);
    wait_results_drained();

    // all-ones type with a length beyond the block, then bad digits
    cfg_write(CFG_TARGET_ID, 16'hFFFF);
    send_word(8'hFF, 1'b1);
    send_word(8'hFF, 1'b0);
    send_text("999", 1'b0);
    send_text("XY0/", 1'b1);
    send_text("XY:", 1'b1);
    wait_results_drained();

    // random blocks, settings changed only while drained
    rand_bytes = 0;
    setting    = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      wait_results_drained();
      set_idle_mode(setting % 4);
      case (setting % 3)
        0:       blen = $urandom_range(0, 8);
        1:       blen = $urandom_range(9, 48);
        default: blen = $urandom_range(49, 300);
      endcase
      tid = pick_target();
      cfg_write(CFG_BLOCK_LENGTH, CFG_DATA_W'(blen));
      cfg_write(CFG_TARGET_ID, tid);
      nblk = $urandom_range(2, 5);
      for (int k = 0; k < nblk && rand_bytes < RANDOM_BYTES; k++) begin
        make_block(blen, tid);
        send_block();
        rand_bytes += blk_bytes.size();
        if ($urandom_range(9) == 0) begin
          send_word(BYTE_W'($urandom), 1'b0);
          rand_bytes++;
        end
      end
      setting++;
    end

    // largest block size, only the head of the block sent
    wait_results_drained();
    set_idle_mode(0);
    tid = pick_target();
    cfg_write(CFG_BLOCK_LENGTH, 16'd4095);
    cfg_write(CFG_TARGET_ID, tid);
    make_block(4095, tid);
    if (blk_bytes.size() > LARGE_BLOCK_BYTES)
      blk_bytes = blk_bytes[0:LARGE_BLOCK_BYTES-1];
    send_block();

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
